// File: src/mpa_pkg.sv
// Shared types and constants of the meter pulse accumulator.
// Used by mpa_ctrl, mpa_dp and the meter_pulse_accumulator top level.
// No dependencies.
package mpa_pkg;

  // Defaults for the top-level parameters
  localparam int METER_INPUTS_DEF = 6;
  localparam int FAIL_LIMIT_DEF   = 10;

  // Meters that have configuration fields, and the most the index can address
  localparam int CFG_METERS = 6;
  localparam int MAX_METERS = 8;

  // Field widths
  localparam int METER_W = 3;
  localparam int JOB_W   = 5;
  localparam int DIG_W   = 6;
  localparam int RAW_W   = 32;
  localparam int CNT_W   = 32;
  localparam int PRE_W   = 16;
  localparam int EXP_W   = 4;
  localparam int FAIL_W  = 4;

  // Channel widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_LO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_HI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECADES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd5;

  localparam logic [JOB_W-1:0]  JOB_LIMIT_RST = 5'd28;
  localparam logic [FAIL_W-1:0] FAIL_SAT      = 4'hF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch the accepted request
    logic req_init;    // first candidate of the round-robin choice
    logic req_scan;    // test a candidate, step on if not enabled
    logic rsp_start;   // evaluate the response
    logic div_step;    // one bit of the prescale division
    logic scale_step;  // one decade multiply, or the final add
    logic out_load;    // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mask_zero;
    logic hit;
    logic ok;
    logic active;
    logic resync;
    logic use_div;
    logic div_last;
    logic exp_zero;
    logic out_free;
  } dp_sts_t;

endpackage

// File: src/mpa_ctrl.sv
// Controller of the meter pulse accumulator: sequences one request at a time.
// Depends on mpa_pkg for the command and status structs.
module mpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tuser,
  output logic               in_tready,
  input  mpa_pkg::dp_sts_t   sts,
  output mpa_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REQ   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RSP   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = in_tuser ? S_RSP : S_REQ;
        end
      end
      S_REQ: begin
        cmd.req_init = 1'b1;
        state_nxt    = sts.mask_zero ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        cmd.req_scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_FIN;
        end
      end
      S_RSP: begin
        cmd.rsp_start = 1'b1;
        if (!sts.ok || !sts.active || sts.resync) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = sts.use_div ? S_DIV : S_SCALE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale_step = 1'b1;
        if (sts.exp_zero) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ($past(state_r) == S_RSP || $past(state_r) == S_DIV))
    else $error("division entered from the wrong state");
`endif

endmodule

// File: src/mpa_dp.sv
// Datapath of the meter pulse accumulator: configuration, per-meter counters,
// round-robin choice, bit-serial divider, decade scaler and output register.
// Depends on mpa_pkg for widths, register indexes and the command/status structs.
module mpa_dp #(
  parameter int METER_INPUTS = mpa_pkg::METER_INPUTS_DEF,
  parameter int FAIL_LIMIT   = mpa_pkg::FAIL_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [mpa_pkg::IN_DATA_W-1:0]       in_tdata,
  input  mpa_pkg::ctrl_cmd_t                  cmd,
  output mpa_pkg::dp_sts_t                    sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mpa_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int MW = (METER_INPUTS > 1) ? $clog2(METER_INPUTS) : 1;
  localparam logic [mpa_pkg::FAIL_W-1:0] FAIL_LIMIT_C = mpa_pkg::FAIL_W'(FAIL_LIMIT);
  localparam logic [mpa_pkg::METER_W:0]  METER_END    = (mpa_pkg::METER_W+1)'(METER_INPUTS);
  localparam int PAD_W = mpa_pkg::OUT_DATA_W - 1 - mpa_pkg::DIG_W - 1 - mpa_pkg::METER_W
                         - mpa_pkg::JOB_W - 2 * mpa_pkg::CNT_W - 1;

  // Configuration
  logic [mpa_pkg::DIG_W-1:0]   enabled_r;
  logic [63:0]                 pre_lo_r;
  logic [31:0]                 pre_hi_r;
  logic [23:0]                 dec_r;
  logic [mpa_pkg::JOB_W-1:0]   job_lim_r;
  logic                        hold_r;

  // Latched request fields
  logic                        ok_r;
  logic [mpa_pkg::DIG_W-1:0]   dig_r;
  logic [mpa_pkg::RAW_W-1:0]   raw_r;

  // Per-meter state
  logic [mpa_pkg::RAW_W-1:0]   last_raw_r  [METER_INPUTS];
  logic [mpa_pkg::PRE_W-1:0]   pre_rem_r   [METER_INPUTS];
  logic [mpa_pkg::CNT_W-1:0]   total_r     [METER_INPUTS];
  logic [mpa_pkg::CNT_W-1:0]   monthly_r   [METER_INPUTS];

  // Link and selection state
  logic [mpa_pkg::FAIL_W-1:0]  fail_cnt_r;
  logic                        err_r;
  logic [mpa_pkg::DIG_W-1:0]   in_latch_r;
  logic                        stat_r;
  logic [mpa_pkg::METER_W-1:0] cur_meter_r;
  logic [mpa_pkg::JOB_W-1:0]   cur_job_r;

  // Working registers
  logic [mpa_pkg::METER_W-1:0] wm_r;
  logic [mpa_pkg::JOB_W-1:0]   wj_r;
  logic [mpa_pkg::PRE_W-1:0]   dv_rem_r;
  logic [mpa_pkg::PRE_W-1:0]   dv_q_r;
  logic [3:0]                  dv_cnt_r;
  logic [mpa_pkg::CNT_W-1:0]   prod_r;
  logic [mpa_pkg::EXP_W-1:0]   exp_cnt_r;
  logic                        counted_r;

  logic                        out_valid_r;
  logic [mpa_pkg::OUT_DATA_W-1:0] out_data_r;

  // Combinational helpers
  logic [mpa_pkg::MAX_METERS-1:0] enabled_ext;
  logic [METER_INPUTS-1:0]     mask;
  logic [MW-1:0]               mi;
  logic [mpa_pkg::RAW_W-1:0]   old_raw;
  logic [mpa_pkg::PRE_W-1:0]   fac;
  logic [mpa_pkg::EXP_W-1:0]   expo;
  logic [mpa_pkg::PRE_W-1:0]   diff;
  logic [mpa_pkg::PRE_W-1:0]   acc;
  logic [mpa_pkg::PRE_W:0]     dv_trial;
  logic [mpa_pkg::PRE_W-1:0]   dv_rem_nxt;
  logic [mpa_pkg::PRE_W-1:0]   dv_q_nxt;
  logic [mpa_pkg::METER_W-1:0] init_m_nxt;
  logic [mpa_pkg::JOB_W-1:0]   init_j_nxt;
  logic [mpa_pkg::METER_W-1:0] scan_m_nxt;
  logic [mpa_pkg::JOB_W-1:0]   scan_j_nxt;

  // Advance the round-robin candidate by one meter, bumping the job on wrap
  function automatic logic [mpa_pkg::METER_W+mpa_pkg::JOB_W-1:0] rr_step(
    input logic [mpa_pkg::METER_W-1:0] m,
    input logic [mpa_pkg::JOB_W-1:0]   j,
    input logic [mpa_pkg::JOB_W-1:0]   lim
  );
    logic [mpa_pkg::METER_W:0] m1;
    logic [mpa_pkg::JOB_W:0]   j1;
    logic [mpa_pkg::METER_W-1:0] mo;
    logic [mpa_pkg::JOB_W-1:0]   jo;
    m1 = {1'b0, m} + 1'b1;
    j1 = {1'b0, j} + 1'b1;
    mo = m1[mpa_pkg::METER_W-1:0];
    jo = j;
    if (m1 >= METER_END) begin
      mo = '0;
      jo = (j1 > {1'b0, lim}) ? mpa_pkg::JOB_W'(1) : j1[mpa_pkg::JOB_W-1:0];
    end
    return {mo, jo};
  endfunction

  assign enabled_ext = {{(mpa_pkg::MAX_METERS-mpa_pkg::DIG_W){1'b0}}, enabled_r};
  assign mask        = enabled_ext[METER_INPUTS-1:0];
  assign mi          = cur_meter_r[MW-1:0];
  assign old_raw     = last_raw_r[mi];
  assign diff        = raw_r[mpa_pkg::PRE_W-1:0] - old_raw[mpa_pkg::PRE_W-1:0];
  assign acc         = pre_rem_r[mi] + diff;

  always_comb begin
    unique case (cur_meter_r)
      3'd0:    fac = pre_lo_r[15:0];
      3'd1:    fac = pre_lo_r[31:16];
      3'd2:    fac = pre_lo_r[47:32];
      3'd3:    fac = pre_lo_r[63:48];
      3'd4:    fac = pre_hi_r[15:0];
      3'd5:    fac = pre_hi_r[31:16];
      default: fac = '0;
    endcase
    unique case (cur_meter_r)
      3'd0:    expo = dec_r[3:0];
      3'd1:    expo = dec_r[7:4];
      3'd2:    expo = dec_r[11:8];
      3'd3:    expo = dec_r[15:12];
      3'd4:    expo = dec_r[19:16];
      3'd5:    expo = dec_r[23:20];
      default: expo = '0;
    endcase
  end

  // One restoring division step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    dv_trial = {dv_rem_r, dv_q_r[mpa_pkg::PRE_W-1]} - {1'b0, fac};
    if (!dv_trial[mpa_pkg::PRE_W]) begin
      dv_rem_nxt = dv_trial[mpa_pkg::PRE_W-1:0];
      dv_q_nxt   = {dv_q_r[mpa_pkg::PRE_W-2:0], 1'b1};
    end else begin
      dv_rem_nxt = {dv_rem_r[mpa_pkg::PRE_W-2:0], dv_q_r[mpa_pkg::PRE_W-1]};
      dv_q_nxt   = {dv_q_r[mpa_pkg::PRE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (cur_job_r == '0) begin
      init_m_nxt = '0;
      init_j_nxt = mpa_pkg::JOB_W'(1);
    end else begin
      {init_m_nxt, init_j_nxt} = rr_step(cur_meter_r, cur_job_r, job_lim_r);
    end
    {scan_m_nxt, scan_j_nxt} = rr_step(wm_r, wj_r, job_lim_r);
  end

  always_comb begin
    sts.mask_zero = (mask == '0);
    sts.hit       = mask[wm_r[MW-1:0]];
    sts.ok        = ok_r;
    sts.active    = (cur_job_r != '0) && mask[mi];
    sts.resync    = (old_raw == '0) || (raw_r < old_raw);
    sts.use_div   = (fac > mpa_pkg::PRE_W'(1));
    sts.div_last  = (dv_cnt_r == 4'hF);
    sts.exp_zero  = (exp_cnt_r == '0);
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= '0;
      pre_lo_r    <= '0;
      pre_hi_r    <= '0;
      dec_r       <= '0;
      job_lim_r   <= mpa_pkg::JOB_LIMIT_RST;
      hold_r      <= 1'b0;
      for (int i = 0; i < METER_INPUTS; i++) begin
        last_raw_r[i] <= '0;
        pre_rem_r[i]  <= '0;
        total_r[i]    <= '0;
        monthly_r[i]  <= '0;
      end
      fail_cnt_r  <= '0;
      err_r       <= 1'b0;
      in_latch_r  <= '0;
      stat_r      <= 1'b0;
      cur_meter_r <= '0;
      cur_job_r   <= '0;
      counted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mpa_pkg::CFG_ENABLED: enabled_r <= cfg_wdata[mpa_pkg::DIG_W-1:0];
          mpa_pkg::CFG_PRE_LO:  pre_lo_r  <= cfg_wdata;
          mpa_pkg::CFG_PRE_HI:  pre_hi_r  <= cfg_wdata[31:0];
          mpa_pkg::CFG_DECADES: dec_r     <= cfg_wdata[23:0];
          mpa_pkg::CFG_JOB_LIM: job_lim_r <= cfg_wdata[mpa_pkg::JOB_W-1:0];
          mpa_pkg::CFG_HOLD:    hold_r    <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        counted_r <= 1'b0;
      end

      if (cmd.req_init && sts.mask_zero) begin
        cur_meter_r <= '0;
        cur_job_r   <= '0;
      end
      if (cmd.req_scan && sts.hit) begin
        cur_meter_r <= wm_r;
        cur_job_r   <= wj_r;
      end

      if (cmd.rsp_start) begin
        if (!ok_r) begin
          if (fail_cnt_r > FAIL_LIMIT_C) begin
            err_r <= 1'b1;
            if (!hold_r) begin
              in_latch_r <= '0;
              stat_r     <= 1'b1;
            end
          end else if (fail_cnt_r != mpa_pkg::FAIL_SAT) begin
            fail_cnt_r <= fail_cnt_r + 1'b1;
          end
        end else begin
          in_latch_r <= dig_r;
          stat_r     <= 1'b0;
          fail_cnt_r <= '0;
          err_r      <= 1'b0;
          if (sts.active) begin
            last_raw_r[mi] <= raw_r;
            if (!sts.resync && !sts.use_div) begin
              counted_r <= (diff != '0);
            end
          end
        end
      end

      if (cmd.div_step && sts.div_last) begin
        pre_rem_r[mi] <= dv_rem_nxt;
        counted_r     <= (dv_q_nxt != '0);
      end

      if (cmd.scale_step && sts.exp_zero) begin
        total_r[mi]   <= total_r[mi] + prod_r;
        monthly_r[mi] <= monthly_r[mi] + prod_r;
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_r  <= in_tdata[0];
      dig_r <= in_tdata[mpa_pkg::DIG_W:1];
      raw_r <= in_tdata[mpa_pkg::DIG_W+mpa_pkg::RAW_W:mpa_pkg::DIG_W+1];
    end

    if (cmd.req_init) begin
      wm_r <= init_m_nxt;
      wj_r <= init_j_nxt;
    end
    if (cmd.req_scan && !sts.hit) begin
      wm_r <= scan_m_nxt;
      wj_r <= scan_j_nxt;
    end

    if (cmd.rsp_start) begin
      dv_rem_r  <= '0;
      dv_q_r    <= acc;
      dv_cnt_r  <= '0;
      prod_r    <= {{(mpa_pkg::CNT_W-mpa_pkg::PRE_W){1'b0}}, diff};
      exp_cnt_r <= expo;
    end

    if (cmd.div_step) begin
      dv_rem_r <= dv_rem_nxt;
      dv_q_r   <= dv_q_nxt;
      dv_cnt_r <= dv_cnt_r + 1'b1;
      if (sts.div_last) begin
        prod_r    <= {{(mpa_pkg::CNT_W-mpa_pkg::PRE_W){1'b0}}, dv_q_nxt};
        exp_cnt_r <= expo;
      end
    end

    // times ten as eight plus two, wrapping at 32 bits
    if (cmd.scale_step && !sts.exp_zero) begin
      prod_r    <= (prod_r << 3) + (prod_r << 1);
      exp_cnt_r <= exp_cnt_r - 1'b1;
    end

    if (cmd.out_load) begin
      out_data_r <= {{PAD_W{1'b0}}, counted_r, monthly_r[mi], total_r[mi], cur_job_r,
                     cur_meter_r, stat_r, in_latch_r, err_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_err_needs_fails: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (fail_cnt_r > FAIL_LIMIT_C))
    else $error("link error flag set without enough failed transfers");

  a_idle_job_meter: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_job_r == '0) |-> (cur_meter_r == '0))
    else $error("meter selected while no job is active");

  a_div_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (dv_rem_r < fac))
    else $error("division remainder not below the prescale factor");
`endif

endmodule

// File: src/meter_pulse_accumulator.sv
// Top level of the meter pulse accumulator: handshake, controller and datapath.
// Depends on mpa_pkg, mpa_ctrl and mpa_dp.
//
// Usage:
//   in_*  : one request per handshake. in_tuser is the opcode (0 prepare the
//           next poll, 1 module response arrived).
//   out_* : exactly one result per request, in order.
//   cfg_* : register writes, taken at any edge with cfg_we high; write only
//           while no request is in flight.
// Timing: one request at a time. A poll with no meter enabled goes straight from
//   its request step to the final step; else the round-robin scan tests one meter
//   a cycle until it finds an enabled one. A response goes straight to the final
//   step on failure, resync or no active job. Counting runs one multiply per
//   decade of the meter's exponent and then the final add, after the bit-serial
//   prescale divider when the factor is above one. in_tready returns the cycle
//   after the result is loaded.
// The result sits in an output register, so the next request is accepted while
// it waits; a stalled receiver holds the block in its final step after that.
// Reset (rst_n low, synchronous) clears configuration to its defaults, all
// per-meter counters and the link state; the block is ready the cycle after.
module meter_pulse_accumulator #(
  parameter int METER_INPUTS = mpa_pkg::METER_INPUTS_DEF,
  parameter int FAIL_LIMIT   = mpa_pkg::FAIL_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // transfer_ok[0], digital_byte[6:1], raw_count[38:7], zero[39]
  input  logic [mpa_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // link_error[0], input_values[6:1], input_status[7], meter_index[10:8],
  // job_number[15:11], total_count[47:16], monthly_count[79:48], counted[80],
  // zero[87:81]
  output logic [mpa_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mpa_pkg::ctrl_cmd_t cmd;
  mpa_pkg::dp_sts_t   sts;

  mpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpa_dp #(
    .METER_INPUTS (METER_INPUTS),
    .FAIL_LIMIT   (FAIL_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
